@@ rtl/ptscs_pkg.sv @@
// Shared types and constants for the picture type start code scanner.
package ptscs_pkg;

	localparam int unsigned MAX_GOLOMB_ZEROS = 31;
	localparam int unsigned GZ_W = $clog2(MAX_GOLOMB_ZEROS + 1);

	localparam logic [1:0] MODE_MPEG2 = 2'd0;
	localparam logic [1:0] MODE_H264  = 2'd1;

	localparam logic [7:0] PIC_TYPE_MASK = 8'h38;
	localparam logic [7:0] PIC_TYPE_I    = 8'h08;
	localparam logic [7:0] NAL_TYPE_MASK = 8'h1f;
	localparam logic [4:0] NAL_SLICE     = 5'd1;
	localparam logic [4:0] NAL_IDR       = 5'd5;

	localparam logic [2:0] BAH_FULL = 3'd4;

	typedef enum logic [1:0] {
		V_NONE  = 2'd0,
		V_INTRA = 2'd1,
		V_OTHER = 2'd2,
		V_ERROR = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_HDR   = 3'd1,
		PH_MP1   = 3'd2,
		PH_MP2   = 3'd3,
		PH_SLICE = 3'd4
	} phase_t;

	// Exp-Golomb decoder state; only the low three suffix bits matter since
	// intra slice types are all below 15.
	typedef struct packed {
		logic [GZ_W-1:0] zero_run;
		logic [GZ_W-1:0] suffix_left;
		logic [2:0]      value;
		logic            second_code;
		verdict_t        pending;
	} gol_t;

endpackage

@@ rtl/ptscs_golomb.sv @@
// Eight Exp-Golomb bit steps over one slice header byte, MSB first.
module ptscs_golomb (
	input  ptscs_pkg::gol_t st_in,
	input  logic [7:0]      data_byte,
	output ptscs_pkg::gol_t st_out
);
	import ptscs_pkg::*;

	gol_t       st;
	logic       bit_v;
	logic [3:0] code_val;

	always_comb begin
		st       = st_in;
		bit_v    = 1'b0;
		code_val = '0;
		for (int i = 7; i >= 0; i--) begin
			bit_v = data_byte[i];
			if (st.pending == V_NONE) begin
				if (st.suffix_left == '0) begin
					if (!bit_v) begin
						if (st.zero_run >= GZ_W'(MAX_GOLOMB_ZEROS))
							st.pending = V_ERROR;
						else
							st.zero_run = st.zero_run + 1'b1;
					end else if (st.zero_run == '0) begin
						// code value 0: never an intra slice type
						if (!st.second_code) begin
							st.second_code = 1'b1;
							st.zero_run    = '0;
							st.value       = '0;
						end else begin
							st.pending = V_OTHER;
						end
					end else begin
						st.suffix_left = st.zero_run;
						st.value       = '0;
					end
				end else begin
					st.value       = {st.value[1:0], bit_v};
					st.suffix_left = st.suffix_left - 1'b1;
					if (st.suffix_left == '0) begin
						code_val = {1'b0, st.value} + ((4'd1 << st.zero_run[1:0]) - 4'd1);
						if (!st.second_code) begin
							st.second_code = 1'b1;
							st.zero_run    = '0;
							st.value       = '0;
						end else if (st.zero_run <= GZ_W'(3) &&
						             (code_val == 4'd2 || code_val == 4'd4 ||
						              code_val == 4'd7 || code_val == 4'd9)) begin
							st.pending = V_INTRA;
						end else begin
							st.pending = V_OTHER;
						end
					end
				end
			end
		end
	end

	assign st_out = st;

endmodule

@@ rtl/ptscs_core.sv @@
// Scan state registers and the per-byte decision logic.
module ptscs_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_mode,
	input  logic                  step,
	input  logic [7:0]            data_byte,
	input  logic                  payload_start,
	input  logic                  payload_end,
	output logic                  has_result,
	output ptscs_pkg::verdict_t   verdict
);
	import ptscs_pkg::*;

	logic [1:0] mode_q;
	logic [1:0] zc_q, zc_n;
	phase_t     ph_q, ph_n;
	logic       dec_q, dec_n;
	logic [2:0] bah_q, bah_n;
	gol_t       gol_q, gol_n, gol_cur, gol_fed;
	logic [4:0] nal_type;

	assign gol_cur  = payload_start ? gol_t'('0) : gol_q;
	assign nal_type = 5'(data_byte & NAL_TYPE_MASK);

	ptscs_golomb u_golomb (
		.st_in     (gol_cur),
		.data_byte (data_byte),
		.st_out    (gol_fed)
	);

	always_comb begin
		zc_n       = payload_start ? 2'd0 : zc_q;
		ph_n       = payload_start ? PH_HUNT : ph_q;
		dec_n      = payload_start ? 1'b0 : dec_q;
		bah_n      = payload_start ? 3'd0 : bah_q;
		gol_n      = gol_cur;
		has_result = 1'b0;
		verdict    = V_NONE;
		if (!dec_n) begin
			if (mode_q[1]) begin
				has_result = 1'b1;
				verdict    = V_INTRA;
			end else begin
				case (ph_n)
					PH_HDR: begin
						ph_n = PH_HUNT;
						zc_n = 2'd0;
						if (mode_q == MODE_MPEG2) begin
							if (data_byte == 8'd0 && !payload_end)
								ph_n = PH_MP1;
						end else if (nal_type == NAL_SLICE || nal_type == NAL_IDR) begin
							if (payload_end) begin
								has_result = 1'b1;
								verdict    = V_OTHER;
							end else begin
								ph_n  = PH_SLICE;
								bah_n = 3'd0;
								gol_n = '0;
							end
						end else if (nal_type inside {[5'd0:5'd5]}) begin
							has_result = 1'b1;
							verdict    = V_OTHER;
						end
					end
					PH_MP1: begin
						if (payload_end) begin
							// short header: rescan this byte from a zero count of 0
							ph_n = PH_HUNT;
							zc_n = (data_byte == 8'd0) ? 2'd1 : 2'd0;
						end else begin
							ph_n = PH_MP2;
						end
					end
					PH_MP2: begin
						has_result = 1'b1;
						verdict = ((data_byte & PIC_TYPE_MASK) == PIC_TYPE_I) ? V_INTRA : V_OTHER;
					end
					PH_SLICE: begin
						if (bah_n < BAH_FULL)
							bah_n = bah_n + 3'd1;
						gol_n = gol_fed;
						if (bah_n >= BAH_FULL) begin
							if (gol_fed.pending != V_NONE) begin
								has_result = 1'b1;
								verdict    = gol_fed.pending;
							end else if (payload_end) begin
								has_result = 1'b1;
								verdict    = V_ERROR;
							end
						end else if (payload_end) begin
							has_result = 1'b1;
							verdict    = V_OTHER;
						end
					end
					default: begin
						ph_n = PH_HUNT;
						if (data_byte == 8'd0) begin
							if (zc_n != 2'd2)
								zc_n = zc_n + 2'd1;
						end else if (data_byte == 8'd1 && zc_n == 2'd2) begin
							zc_n = 2'd0;
							ph_n = PH_HDR;
						end else begin
							zc_n = 2'd0;
						end
					end
				endcase
			end
			if (has_result) begin
				dec_n = 1'b1;
				ph_n  = PH_HUNT;
			end else if (payload_end) begin
				has_result = 1'b1;
				verdict    = V_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MPEG2;
			zc_q   <= '0;
			ph_q   <= PH_HUNT;
			dec_q  <= 1'b0;
			bah_q  <= '0;
			gol_q  <= '0;
		end else if (cfg_we) begin
			mode_q <= cfg_mode;
			zc_q   <= '0;
			ph_q   <= PH_HUNT;
			dec_q  <= 1'b0;
			bah_q  <= '0;
			gol_q  <= '0;
		end else if (step) begin
			zc_q  <= zc_n;
			ph_q  <= ph_n;
			dec_q <= dec_n;
			bah_q <= bah_n;
			gol_q <= gol_n;
		end
	end

	// once decided, only a new payload or a configuration write can produce another transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		step && dec_q && !payload_start |-> !has_result)
		else $error("result produced after decision");

	assert property (@(posedge clk) disable iff (!arst_n)
		step && !cfg_we && has_result && verdict != V_NONE |=> dec_q && ph_q == PH_HUNT)
		else $error("decision not recorded");

	assert property (@(posedge clk) disable iff (!arst_n)
		bah_q <= BAH_FULL)
		else $error("byte counter past saturation");

endmodule

@@ rtl/picture_type_start_code_scanner.sv @@
// Top level: input stage, scanner core and result register.
//
// Finds picture / slice start codes in PES payload bytes and reports the
// coding type of the first picture or slice in each payload.
// Input channel (in_valid/in_ready): one payload byte per transaction with
// payload_start and payload_end flags. Output channel (out_valid/out_ready):
// a verdict when a decision is made, or verdict 0 on payload_end if none was.
// Configuration channel (cfg_valid/cfg_ready): writes codec_mode and clears
// the scan state; it is taken only while the input stage is empty.
// A byte in the input stage is evaluated by the core and its verdict is
// registered. Throughput is one byte per cycle unless the receiver stalls;
// the limit is the eight-step Exp-Golomb chain in the core stage.
// Reset clears codec_mode to MPEG-2 and empties both registers.
// When the receiver stalls, the verdict is held in the result register and
// the input stage keeps flowing for bytes that produce no result; a byte that
// produces one waits in the input stage, which drops in_ready.
module picture_type_start_code_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                payload_start,
	input  logic                payload_end,
	output logic                out_valid,
	input  logic                out_ready,
	output ptscs_pkg::verdict_t verdict,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          codec_mode
);
	import ptscs_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       end_s1;
	logic       out_valid_q;
	verdict_t   verdict_q;
	logic       has_result;
	verdict_t   core_verdict;
	logic       out_free;
	logic       advance;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s1 && (!has_result || out_free);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = !valid_s1;
	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;

	ptscs_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_mode      (codec_mode),
		.step          (advance),
		.data_byte     (byte_s1),
		.payload_start (start_s1),
		.payload_end   (end_s1),
		.has_result    (has_result),
		.verdict       (core_verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= payload_start;
			end_s1   <= payload_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result)
			verdict_q <= core_verdict;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(advance && has_result))
		else $error("result register overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && has_result |=> out_valid_q)
		else $error("result not registered");

endmodule
